[design/kol_pkg.sv]
// kol_pkg: token kinds, character constants and byte classification helpers
// shared by the keyword/operator lexer scanner, its top level and the checker
// no dependencies
package kol_pkg;

    // token kinds as seen on the result channel
    typedef enum logic [4:0] {
        KIND_IDENT  = 5'd0,
        KIND_NUMBER = 5'd1,
        KIND_PRINT  = 5'd2,
        KIND_IF     = 5'd3,
        KIND_WHILE  = 5'd4,
        KIND_EQEQ   = 5'd5,
        KIND_PLUS   = 5'd6,
        KIND_MINUS  = 5'd7,
        KIND_STAR   = 5'd8,
        KIND_SLASH  = 5'd9,
        KIND_LPAREN = 5'd10,
        KIND_RPAREN = 5'd11,
        KIND_LBRACE = 5'd12,
        KIND_RBRACE = 5'd13,
        KIND_ASSIGN = 5'd14,
        KIND_SEMI   = 5'd15,
        KIND_GT     = 5'd16,
        KIND_LT     = 5'd17,
        KIND_END    = 5'd18
    } kind_t;

    localparam int START_BITS  = 16;
    localparam int LENGTH_BITS = 8;

    // one result beat
    typedef struct packed {
        kind_t                  kind;
        logic [START_BITS-1:0]  start;
        logic [LENGTH_BITS-1:0] length;
        logic                   overflow;
        logic                   last;
    } token_t;

    // up to two results caused by one input beat, in delivery order
    typedef struct packed {
        token_t     tok0;
        token_t     tok1;
        logic [1:0] count;
    } scan_out_t;

    localparam logic [39:0] KW_PRINT_TEXT = "print";
    localparam logic [15:0] KW_IF_TEXT    = "if";
    localparam logic [39:0] KW_WHILE_TEXT = "while";
    localparam int          KW_PRINT_LEN  = 5;
    localparam int          KW_IF_LEN     = 2;
    localparam int          KW_WHILE_LEN  = 5;
    localparam int          KW_MAX_LEN    = 5;

    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_LT     = 8'h3C;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    // single-byte operator kind, KIND_IDENT when the byte is not one
    function automatic kind_t single_kind(input logic [7:0] b);
        kind_t k;
        case (b)
            CHAR_PLUS:   k = KIND_PLUS;
            CHAR_MINUS:  k = KIND_MINUS;
            CHAR_STAR:   k = KIND_STAR;
            CHAR_SLASH:  k = KIND_SLASH;
            CHAR_LPAREN: k = KIND_LPAREN;
            CHAR_RPAREN: k = KIND_RPAREN;
            CHAR_LBRACE: k = KIND_LBRACE;
            CHAR_RBRACE: k = KIND_RBRACE;
            CHAR_SEMI:   k = KIND_SEMI;
            CHAR_GT:     k = KIND_GT;
            CHAR_LT:     k = KIND_LT;
            default:     k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // which keywords still match byte b at character index idx
    // bit 0 print, bit 1 if, bit 2 while
    function automatic logic [2:0] kw_hit(input logic [2:0] idx, input logic [7:0] b);
        logic [2:0] hit;
        case (idx)
            3'd0: hit = {b == KW_WHILE_TEXT[39:32], b == KW_IF_TEXT[15:8],
                         b == KW_PRINT_TEXT[39:32]};
            3'd1: hit = {b == KW_WHILE_TEXT[31:24], b == KW_IF_TEXT[7:0],
                         b == KW_PRINT_TEXT[31:24]};
            3'd2: hit = {b == KW_WHILE_TEXT[23:16], 1'b0, b == KW_PRINT_TEXT[23:16]};
            3'd3: hit = {b == KW_WHILE_TEXT[15:8], 1'b0, b == KW_PRINT_TEXT[15:8]};
            3'd4: hit = {b == KW_WHILE_TEXT[7:0], 1'b0, b == KW_PRINT_TEXT[7:0]};
            default: hit = 3'b000;
        endcase
        return hit;
    endfunction

endpackage

[design/kol_scan.sv]
// kol_scan: lexer scan state and per-beat token decision
// one source byte per accepted beat, up to two tokens out; uses kol_pkg
module kol_scan #(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        text_byte,
    input  logic              end_of_text,
    output kol_pkg::scan_out_t result
);

    localparam int LW = $clog2(MAX_TOKEN_LENGTH + 1);

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_ASSIGN = 4'b1000
    } mode_t;

    mode_t                    mode_reg,  mode_next;
    logic [POSITION_BITS-1:0] pos_reg,   pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LW-1:0]            len_reg,   len_next;
    logic                     ovf_reg,   ovf_next;
    logic [2:0]               cand_reg,  cand_next;

    logic          is_al, is_dg, is_sp, is_eq;
    kol_pkg::kind_t op_kind;
    logic [2:0]    kw_idx;
    logic          fin_valid, new_valid, taken;
    kol_pkg::token_t fin_tok, new_tok;
    kol_pkg::kind_t fin_kind;

    assign is_al   = kol_pkg::is_alpha(text_byte);
    assign is_dg   = kol_pkg::is_digit(text_byte);
    assign is_sp   = kol_pkg::is_space(text_byte);
    assign is_eq   = (text_byte == kol_pkg::CHAR_EQ);
    assign op_kind = kol_pkg::single_kind(text_byte);
    // index past every keyword maps to a code with no hit
    assign kw_idx  = (len_reg < LW'(kol_pkg::KW_MAX_LEN)) ? len_reg[2:0] : 3'd7;

    // kind of the pending run if it were finished now
    always_comb
    begin
        fin_kind = kol_pkg::KIND_IDENT;
        case (mode_reg)
            MODE_ASSIGN: fin_kind = kol_pkg::KIND_ASSIGN;
            MODE_NUMBER: fin_kind = kol_pkg::KIND_NUMBER;
            default:
            begin
                if (!ovf_reg)
                begin
                    if (cand_reg[0] && len_reg == LW'(kol_pkg::KW_PRINT_LEN))
                        fin_kind = kol_pkg::KIND_PRINT;
                    else if (cand_reg[1] && len_reg == LW'(kol_pkg::KW_IF_LEN))
                        fin_kind = kol_pkg::KIND_IF;
                    else if (cand_reg[2] && len_reg == LW'(kol_pkg::KW_WHILE_LEN))
                        fin_kind = kol_pkg::KIND_WHILE;
                end
            end
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        cand_next  = cand_reg;
        taken      = 1'b0;
        fin_valid  = 1'b0;
        new_valid  = 1'b0;

        fin_tok.kind     = fin_kind;
        fin_tok.start    = kol_pkg::START_BITS'(start_reg);
        fin_tok.length   = kol_pkg::LENGTH_BITS'(len_reg);
        fin_tok.overflow = ovf_reg;
        fin_tok.last     = 1'b0;

        new_tok.kind     = op_kind;
        new_tok.start    = kol_pkg::START_BITS'(pos_reg);
        new_tok.length   = kol_pkg::LENGTH_BITS'(1);
        new_tok.overflow = 1'b0;
        new_tok.last     = 1'b0;

        if (end_of_text)
        begin
            fin_valid      = (mode_reg != MODE_IDLE);
            new_valid      = 1'b1;
            new_tok.kind   = kol_pkg::KIND_END;
            new_tok.length = '0;
            mode_next      = MODE_IDLE;
            pos_next       = '0;
            start_next     = '0;
            len_next       = '0;
            ovf_next       = 1'b0;
            cand_next      = 3'b111;
        end
        else
        begin
            case (mode_reg)
                MODE_ASSIGN:
                begin
                    fin_valid = 1'b1;
                    mode_next = MODE_IDLE;
                    if (is_eq)
                    begin
                        // second '=' makes the pair
                        fin_tok.kind     = kol_pkg::KIND_EQEQ;
                        fin_tok.length   = kol_pkg::LENGTH_BITS'(2);
                        fin_tok.overflow = 1'b0;
                        taken            = 1'b1;
                    end
                end
                MODE_IDENT, MODE_NUMBER:
                begin
                    if (is_dg || (is_al && mode_reg == MODE_IDENT))
                    begin
                        taken = 1'b1;
                        if (mode_reg == MODE_IDENT)
                            cand_next = cand_reg & kol_pkg::kw_hit(kw_idx, text_byte);
                        if (len_reg < LW'(MAX_TOKEN_LENGTH))
                            len_next = len_reg + 1'b1;
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        fin_valid = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                default: ;
            endcase

            if (!taken && !is_sp)
            begin
                if (is_al || is_dg || is_eq)
                begin
                    mode_next  = is_al ? MODE_IDENT : (is_dg ? MODE_NUMBER : MODE_ASSIGN);
                    start_next = pos_reg;
                    len_next   = LW'(1);
                    ovf_next   = 1'b0;
                    cand_next  = is_al ? kol_pkg::kw_hit(3'd0, text_byte) : 3'b111;
                end
                else
                    new_valid = (op_kind != kol_pkg::KIND_IDENT);
            end
            pos_next = pos_reg + 1'b1;
        end

        new_tok.last = 1'b1;
        fin_tok.last = !new_valid;

        result.tok0  = fin_valid ? fin_tok : new_tok;
        result.tok1  = new_tok;
        result.count = {1'b0, fin_valid} + {1'b0, new_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            cand_reg  <= 3'b111;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            cand_reg  <= cand_next;
        end
    end

endmodule

[design/keyword_operator_lexer_top.sv]
// keyword_operator_lexer_top: streaming lexer top level with result queue
// depends on kol_pkg and kol_scan
//
// usage
//   input stream: one source byte per beat in s_axis_tdata[7:0]; a beat with
//   s_axis_tlast high is the end marker, its data byte is ignored, it
//   finishes any pending token, emits an END token and restarts offsets at 0
//   output stream: one token per beat, kind in m_axis_tuser, start offset,
//   length and overflow flag in m_axis_tdata; m_axis_tlast marks the final
//   token caused by one input beat
// queueing: a token is registered into the result queue by the input beat that
//   completes it (identifiers, numbers and '=' complete on the following beat)
// throughput: one input beat per cycle; the second token of a beat that yields
//   two tokens waits in the four-entry result queue, so the input
//   side only waits when the output side is stalled or falls behind
// stall: s_axis_tready drops while the queue holds more than two tokens,
//   since any beat may add two; queued tokens are held until taken
// reset: rst_n clears the scan state (idle, offset 0) and empties the queue
module keyword_operator_lexer_top #(
    parameter int MAX_TOKEN_LENGTH = 255,
    parameter int POSITION_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] token_start, [23:16] token_length,
                                        // [24] length_overflow, [31:25] zero
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    logic               in_beat, out_beat;
    kol_pkg::scan_out_t scan_res;

    // result queue
    kol_pkg::token_t    queue_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]       count_reg,  count_next;
    kol_pkg::token_t    head;

    assign s_axis_tready = (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    kol_scan #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .POSITION_BITS    (POSITION_BITS)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_beat),
        .text_byte   (s_axis_tdata),
        .end_of_text (s_axis_tlast),
        .result      (scan_res)
    );

    // pointer and fill bookkeeping; pushes are 0, 1 or 2 tokens per beat
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_beat)
        begin
            wr_ptr_next = wr_ptr_reg + QAW'(scan_res.count);
            count_next  = count_next + (QAW+1)'(scan_res.count);
        end
        if (out_beat)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            count_next  = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat && scan_res.count != 2'd0)
            queue_reg[wr_ptr_reg] <= scan_res.tok0;
        if (in_beat && scan_res.count == 2'd2)
            queue_reg[QAW'(wr_ptr_reg + 1'b1)] <= scan_res.tok1;
    end

    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {7'd0, head.overflow, head.length, head.start};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

[design/kol_checker.sv]
// kol_checker: port-level assertions for keyword_operator_lexer_top
// bound to the top level below; uses kol_pkg kind codes
module kol_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // an accepted end marker always yields a token next cycle
    a_end_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
        else $error("end marker produced no result");

    // END closes its run with zero length and no overflow
    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kol_pkg::KIND_END |->
            m_axis_tlast && m_axis_tdata[23:16] == 8'd0 && !m_axis_tdata[24])
        else $error("malformed END token");

    // == is always two bytes long
    a_eqeq_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == kol_pkg::KIND_EQEQ |->
            m_axis_tdata[23:16] == 8'd2 && !m_axis_tdata[24])
        else $error("== token with wrong length");

endmodule

bind keyword_operator_lexer_top kol_checker u_kol_checker (.*);
